FILE: sv/adjacency_matrix_graph_store_top_defines.svh
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_TOP_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define AMG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AMG_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AMG_ASSERT(lbl, prop, msg)
`define AMG_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: sv/amg_pkg.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: package
// Operation and status codes and the fixed widths of the stream fields.
// ----------------------------------------------------------------------------
package amg_pkg;

    localparam int FUNC_W      = 2;
    localparam int NODE_W      = 4;
    localparam int FIELD_VAL_W = 32;
    localparam int STATUS_W    = 3;
    localparam int NCOUNT_W    = 5;
    localparam int ECOUNT_W    = 9;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 56;

    localparam logic [FUNC_W-1:0] FUNC_ADD_NODE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM_EDGE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REM_NODE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NODE_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EDGE_EXISTS  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_EDGE     = 3'd4;

endpackage

FILE: sv/amg_matrix_ram.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: matrix RAM
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module amg_matrix_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/adjacency_matrix_graph_store_top.sv
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: top level
// Node slot table and adjacency matrix with add and remove operations.
// ----------------------------------------------------------------------------
// One operation is taken at a time and s_axis_tready stays low until its
// result has been loaded into the output register. Add node examines the
// slots in order until it finds a free one or reaches the last, add edge and
// remove edge read both matrix words and, if the operation succeeds, write one
// word or, in undirected mode, both, and remove node sweeps its row and then
// its column through the single read and write port of the matrix RAM. An edge
// operation or a node removal that names a missing node goes straight from the
// check to the output state. After reset the matrix RAM is cleared one word per
// cycle, and no transfer is accepted until that pass ends; configuration writes
// are taken throughout.
`include "adjacency_matrix_graph_store_top_defines.svh"

module adjacency_matrix_graph_store_top #(
    parameter int MAX_NODES   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,   // directed
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // node_a, node_b, node_value, edge_value
    input  logic [amg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [amg_pkg::FUNC_W-1:0]      s_axis_tuser, // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // node_label, value_out, node_count, edge_count, zero padding
    output logic [amg_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [amg_pkg::STATUS_W-1:0]    m_axis_tuser  // status
);

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int NC_W   = $clog2(MAX_NODES + 1);
    localparam int EC_W   = $clog2(MAX_NODES * MAX_NODES + 1);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_RD_AB    = 4'd4;
    localparam logic [3:0] S_RD_BA    = 4'd5;
    localparam logic [3:0] S_EDGE_DEC = 4'd6;
    localparam logic [3:0] S_EDGE_WR2 = 4'd7;
    localparam logic [3:0] S_ROW      = 4'd8;
    localparam logic [3:0] S_COL      = 4'd9;
    localparam logic [3:0] S_DRAIN    = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;
    localparam logic [3:0] S_OUT      = 4'd12;

    logic [3:0]                   state_reg;
    logic [3:0]                   state_next;
    logic                         directed_reg;

    logic [amg_pkg::FUNC_W-1:0]   func_reg;
    logic [amg_pkg::NODE_W-1:0]   a_reg;
    logic [amg_pkg::NODE_W-1:0]   b_reg;
    logic [VALUE_WIDTH-1:0]       nval_reg;
    logic [VALUE_WIDTH-1:0]       eval_reg;
    logic [IDX_W-1:0]             a_idx;
    logic [IDX_W-1:0]             b_idx;
    logic                         a_ok;
    logic                         b_ok;

    logic [MAX_NODES-1:0]         node_valid_reg;
    logic [NC_W-1:0]              node_cnt_reg;
    logic [EC_W-1:0]              edge_cnt_reg;
    logic [IDX_W-1:0]             i_reg;
    logic                         i_last;
    logic [ADDR_W-1:0]            clr_reg;
    logic                         slot_free;

    logic [VALUE_WIDTH-1:0]       w_ab_reg;
    logic                         ab_nz;
    logic                         ba_nz;
    logic                         edge_exists;
    logic                         edge_add_ok;

    logic [MAX_NODES-1:0]         out_bits_reg;
    logic [EC_W-1:0]              k_reg;
    logic [1:0]                   k_inc;
    logic                         pend_reg;
    logic                         pend_col_reg;
    logic [IDX_W-1:0]             pend_idx_reg;

    logic [VALUE_WIDTH-1:0]       ns_mem [0:(1 << IDX_W)-1];
    logic [VALUE_WIDTH-1:0]       ns_rd_reg;

    logic [amg_pkg::STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]             res_label_reg;
    logic [VALUE_WIDTH-1:0]       res_value_reg;

    logic                         out_valid_reg;
    logic                         out_load;
    logic [amg_pkg::STATUS_W-1:0] out_status_reg;
    logic [amg_pkg::NODE_W-1:0]   out_label_reg;
    logic [amg_pkg::FIELD_VAL_W-1:0] out_value_reg;
    logic [amg_pkg::NCOUNT_W-1:0] out_nc_reg;
    logic [amg_pkg::ECOUNT_W-1:0] out_ec_reg;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [VALUE_WIDTH-1:0]       ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [VALUE_WIDTH-1:0]       ram_rdata;

    amg_matrix_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    assign a_idx = IDX_W'(a_reg);
    assign b_idx = IDX_W'(b_reg);
    assign a_ok  = (32'(a_reg) < MAX_NODES) && node_valid_reg[a_idx];
    assign b_ok  = (32'(b_reg) < MAX_NODES) && node_valid_reg[b_idx];

    assign i_last    = (32'(i_reg) == MAX_NODES - 1);
    assign slot_free = !node_valid_reg[i_reg];

    assign ab_nz       = (w_ab_reg != '0);
    assign ba_nz       = (ram_rdata != '0);
    assign edge_exists = ab_nz || (!directed_reg && ba_nz);
    assign edge_add_ok = (eval_reg != '0) && !edge_exists;

    always_comb
    begin
        if (directed_reg && (pend_idx_reg != a_idx))
        begin
            k_inc = {1'b0, out_bits_reg[pend_idx_reg]} + {1'b0, ba_nz};
        end
        else
        begin
            k_inc = {1'b0, out_bits_reg[pend_idx_reg] | ba_nz};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (func_reg) inside
                    amg_pkg::FUNC_ADD_NODE:
                    begin
                        state_next = S_SCAN;
                    end
                    amg_pkg::FUNC_ADD_EDGE, amg_pkg::FUNC_REM_EDGE:
                    begin
                        state_next = (a_ok && b_ok) ? S_RD_AB : S_OUT;
                    end
                    default:
                    begin
                        state_next = a_ok ? S_ROW : S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (slot_free || i_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_RD_AB:
            begin
                ram_raddr  = {a_idx, b_idx};
                state_next = S_RD_BA;
            end
            S_RD_BA:
            begin
                ram_raddr  = {b_idx, a_idx};
                state_next = S_EDGE_DEC;
            end
            S_EDGE_DEC:
            begin
                state_next = S_OUT;
                if (func_reg == amg_pkg::FUNC_ADD_EDGE ? edge_add_ok : edge_exists)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {a_idx, b_idx};
                    ram_wdata = (func_reg == amg_pkg::FUNC_ADD_EDGE) ? eval_reg : '0;
                    if (!directed_reg)
                    begin
                        state_next = S_EDGE_WR2;
                    end
                end
            end
            S_EDGE_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {b_idx, a_idx};
                ram_wdata  = (func_reg == amg_pkg::FUNC_ADD_EDGE) ? eval_reg : '0;
                state_next = S_OUT;
            end
            S_ROW:
            begin
                ram_we    = 1'b1;
                ram_waddr = {a_idx, i_reg};
                ram_raddr = {a_idx, i_reg};
                if (i_last)
                begin
                    state_next = S_COL;
                end
            end
            S_COL:
            begin
                ram_we    = 1'b1;
                ram_waddr = {i_reg, a_idx};
                ram_raddr = {i_reg, a_idx};
                if (i_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            directed_reg   <= 1'b0;
            node_valid_reg <= '0;
            node_cnt_reg   <= '0;
            edge_cnt_reg   <= '0;
            i_reg          <= '0;
            clr_reg        <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_col_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= (state_reg == S_ROW) || (state_reg == S_COL);
            pend_col_reg <= (state_reg == S_COL);

            if (cfg_we)
            begin
                directed_reg <= cfg_wdata;
            end

            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (state_reg == S_CHECK)
            begin
                i_reg <= '0;
                k_reg <= '0;
            end
            else if ((state_reg == S_SCAN) || (state_reg == S_ROW) || (state_reg == S_COL))
            begin
                i_reg <= i_last ? '0 : i_reg + 1'b1;
            end

            if (pend_reg && pend_col_reg)
            begin
                k_reg <= k_reg + EC_W'(k_inc);
            end

            if ((state_reg == S_SCAN) && slot_free)
            begin
                node_valid_reg[i_reg] <= 1'b1;
                node_cnt_reg          <= node_cnt_reg + 1'b1;
            end

            if ((state_reg == S_EDGE_DEC) && (func_reg == amg_pkg::FUNC_ADD_EDGE)
                && edge_add_ok)
            begin
                edge_cnt_reg <= edge_cnt_reg + 1'b1;
            end

            if ((state_reg == S_EDGE_DEC) && (func_reg == amg_pkg::FUNC_REM_EDGE)
                && edge_exists && (edge_cnt_reg != '0))
            begin
                edge_cnt_reg <= edge_cnt_reg - 1'b1;
            end

            if (state_reg == S_FIN)
            begin
                node_valid_reg[a_idx] <= 1'b0;
                edge_cnt_reg <= (edge_cnt_reg >= k_reg) ? edge_cnt_reg - k_reg : '0;
                if (node_cnt_reg != '0)
                begin
                    node_cnt_reg <= node_cnt_reg - 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg       <= s_axis_tuser;
            a_reg          <= s_axis_tdata[3:0];
            b_reg          <= s_axis_tdata[7:4];
            nval_reg       <= VALUE_WIDTH'(s_axis_tdata[39:8]);
            eval_reg       <= VALUE_WIDTH'(s_axis_tdata[71:40]);
            res_status_reg <= amg_pkg::STATUS_OK;
            res_label_reg  <= '0;
            res_value_reg  <= '0;
        end

        if (state_reg == S_CHECK)
        begin
            ns_rd_reg <= ns_mem[a_idx];
            if ((func_reg == amg_pkg::FUNC_REM_NODE) ? !a_ok :
                ((func_reg != amg_pkg::FUNC_ADD_NODE) && !(a_ok && b_ok)))
            begin
                res_status_reg <= amg_pkg::STATUS_NODE_MISSING;
            end
        end

        if (state_reg == S_SCAN)
        begin
            if (slot_free)
            begin
                ns_mem[i_reg] <= nval_reg;
                res_label_reg <= i_reg;
            end
            else if (i_last)
            begin
                res_status_reg <= amg_pkg::STATUS_NO_SLOT;
            end
        end

        if (state_reg == S_RD_BA)
        begin
            w_ab_reg <= ram_rdata;
        end

        if (state_reg == S_EDGE_DEC)
        begin
            if (func_reg == amg_pkg::FUNC_ADD_EDGE)
            begin
                if (eval_reg == '0)
                begin
                    res_status_reg <= amg_pkg::STATUS_BAD_EDGE;
                end
                else if (edge_exists)
                begin
                    res_status_reg <= amg_pkg::STATUS_EDGE_EXISTS;
                end
            end
            else if (!edge_exists)
            begin
                res_status_reg <= amg_pkg::STATUS_BAD_EDGE;
            end
            else
            begin
                res_value_reg <= ab_nz ? w_ab_reg : ram_rdata;
            end
        end

        if (pend_reg && !pend_col_reg)
        begin
            out_bits_reg[pend_idx_reg] <= ba_nz;
        end
        pend_idx_reg <= i_reg;

        if (state_reg == S_FIN)
        begin
            res_value_reg <= ns_rd_reg;
        end

        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_label_reg  <= amg_pkg::NODE_W'(res_label_reg);
            out_value_reg  <= amg_pkg::FIELD_VAL_W'(res_value_reg);
            out_nc_reg     <= amg_pkg::NCOUNT_W'(node_cnt_reg);
            out_ec_reg     <= amg_pkg::ECOUNT_W'(edge_cnt_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_ec_reg, out_nc_reg, out_value_reg, out_label_reg};

    `AMG_ASSERT(a_node_count, 32'(node_cnt_reg) == $countones(node_valid_reg), "node count differs from occupied slots")
    `AMG_ASSERT_NEVER(a_edge_bound, 32'(edge_cnt_reg) > MAX_NODES * MAX_NODES, "edge count above matrix size")
    `AMG_ASSERT(a_out_seq, $rose(out_valid_reg) |-> $past(state_reg) == S_OUT, "result raised outside output state")
    `AMG_ASSERT(a_mirror, (state_reg == S_EDGE_DEC && ram_we && !directed_reg) |=> state_reg == S_EDGE_WR2, "mirror write skipped")

endmodule

FILE: test/adjacency_matrix_graph_store_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: self-checking testbench
// A queue of graph operations feeds a stream driver. A monitor compares every
// result transfer with the reply that the testbench's own graph model
// predicts. The run starts with directed cases in both graph modes, then
// moves on to random phases that mostly address live nodes and edges, with
// the mode set anew before each phase.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_top_test;

    localparam int NODES = 16;

    typedef struct {
        logic [amg_pkg::FUNC_W-1:0]      func;
        logic [amg_pkg::NODE_W-1:0]      a;
        logic [amg_pkg::NODE_W-1:0]      b;
        logic [amg_pkg::FIELD_VAL_W-1:0] nval;
        logic [amg_pkg::FIELD_VAL_W-1:0] eval;
    } graph_op_t;

    typedef struct {
        logic [amg_pkg::STATUS_W-1:0]    status;
        logic [amg_pkg::NODE_W-1:0]      label;
        logic [amg_pkg::FIELD_VAL_W-1:0] vout;
        logic [amg_pkg::NCOUNT_W-1:0]    ncount;
        logic [amg_pkg::ECOUNT_W-1:0]    ecount;
    } graph_reply_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic                          cfg_wdata = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [amg_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [amg_pkg::FUNC_W-1:0]    s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [amg_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [amg_pkg::STATUS_W-1:0]  m_axis_tuser;

    graph_op_t    pending_ops[$];
    graph_reply_t awaited_replies[$];
    graph_op_t    op_on_bus;

    bit                              slot_used [NODES];
    logic [amg_pkg::FIELD_VAL_W-1:0] slot_value [NODES];
    logic [amg_pkg::FIELD_VAL_W-1:0] link_word [NODES][NODES];
    int unsigned                     node_total;
    int unsigned                     edge_total;
    bit                              directed_mode;

    bit          calm;
    int unsigned send_hold;
    int unsigned take_hold;
    int unsigned mismatches;
    int unsigned result_index;

    adjacency_matrix_graph_store_top #(
        .MAX_NODES   (NODES),
        .VALUE_WIDTH (32)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic graph_reply_t apply_graph_op(graph_op_t op);
        graph_reply_t r;
        int           slot;
        int unsigned  k;
        logic [31:0]  w;
        bit           out_e;
        bit           in_e;
        r = '{default: '0};
        case (op.func)
            amg_pkg::FUNC_ADD_NODE:
            begin
                slot = 0;
                while (slot < NODES && slot_used[slot])
                    slot++;
                if (slot >= NODES)
                    r.status = amg_pkg::STATUS_NO_SLOT;
                else
                begin
                    slot_used[slot] = 1'b1;
                    slot_value[slot] = op.nval;
                    node_total++;
                    r.label = 4'(slot);
                end
            end
            amg_pkg::FUNC_ADD_EDGE:
            begin
                if (!slot_used[op.a] || !slot_used[op.b])
                    r.status = amg_pkg::STATUS_NODE_MISSING;
                else if (op.eval == 0)
                    r.status = amg_pkg::STATUS_BAD_EDGE;
                else if (link_word[op.a][op.b] != 0 ||
                         (!directed_mode && link_word[op.b][op.a] != 0))
                    r.status = amg_pkg::STATUS_EDGE_EXISTS;
                else
                begin
                    link_word[op.a][op.b] = op.eval;
                    if (!directed_mode)
                        link_word[op.b][op.a] = op.eval;
                    edge_total++;
                end
            end
            amg_pkg::FUNC_REM_EDGE:
            begin
                if (!slot_used[op.a] || !slot_used[op.b])
                    r.status = amg_pkg::STATUS_NODE_MISSING;
                else
                begin
                    w = link_word[op.a][op.b];
                    if (w == 0 && !directed_mode)
                        w = link_word[op.b][op.a];
                    if (w == 0)
                        r.status = amg_pkg::STATUS_BAD_EDGE;
                    else
                    begin
                        link_word[op.a][op.b] = '0;
                        if (!directed_mode)
                            link_word[op.b][op.a] = '0;
                        r.vout = w;
                        if (edge_total > 0)
                            edge_total--;
                    end
                end
            end
            default:
            begin
                if (!slot_used[op.a])
                    r.status = amg_pkg::STATUS_NODE_MISSING;
                else
                begin
                    k = 0;
                    for (int i = 0; i < NODES; i++)
                    begin
                        out_e = link_word[op.a][i] != 0;
                        in_e = link_word[i][op.a] != 0;
                        if (directed_mode && i != int'(op.a))
                            k += int'(out_e) + int'(in_e);
                        else if (out_e || in_e)
                            k++;
                        link_word[op.a][i] = '0;
                        link_word[i][op.a] = '0;
                    end
                    edge_total = (k > edge_total) ? 0 : edge_total - k;
                    slot_used[op.a] = 1'b0;
                    r.vout = slot_value[op.a];
                    if (node_total > 0)
                        node_total--;
                end
            end
        endcase
        r.ncount = 5'(node_total);
        r.ecount = 9'(edge_total);
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_node();
        int unsigned start;
        int unsigned n;
        start = $urandom_range(0, NODES - 1);
        if ($urandom_range(0, 9) < 8)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                n = (start + i) % NODES;
                if (slot_used[n])
                    return 4'(n);
            end
        end
        return 4'(start);
    endfunction

    task automatic queue_op(logic [1:0] func, logic [3:0] a, logic [3:0] b,
                            logic [31:0] nval, logic [31:0] eval);
        graph_op_t op;
        op.func = func;
        op.a = a;
        op.b = b;
        op.nval = nval;
        op.eval = eval;
        pending_ops.push_back(op);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_ops.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_mode(bit mode);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        directed_mode = mode;
    endtask

    task automatic run_random_phase(int unsigned count, int unsigned add_weight);
        graph_op_t   op;
        int unsigned roll;
        int unsigned t_edge;
        int unsigned t_cut;
        int unsigned start;
        int unsigned spot;
        logic [3:0]  tmp;
        bit          found;
        t_edge = add_weight + (100 - add_weight) * 45 / 100;
        t_cut = t_edge + (100 - add_weight) * 35 / 100;
        repeat (count)
        begin
            @(negedge clk);
            while (pending_ops.size() != 0)
                @(negedge clk);
            roll = $urandom_range(0, 99);
            op.a = pick_node();
            op.b = pick_node();
            op.nval = rand_word();
            op.eval = rand_word();
            if (roll < add_weight)
                op.func = amg_pkg::FUNC_ADD_NODE;
            else if (roll < t_edge)
                op.func = amg_pkg::FUNC_ADD_EDGE;
            else if (roll < t_cut)
            begin
                op.func = amg_pkg::FUNC_REM_EDGE;
                found = 1'b0;
                start = $urandom_range(0, NODES * NODES - 1);
                if ($urandom_range(0, 9) < 8)
                begin
                    for (int i = 0; i < NODES * NODES && !found; i++)
                    begin
                        spot = (start + i) % (NODES * NODES);
                        if (link_word[spot / NODES][spot % NODES] != 0)
                        begin
                            op.a = 4'(spot / NODES);
                            op.b = 4'(spot % NODES);
                            found = 1'b1;
                        end
                    end
                    if (found && $urandom_range(0, 1) == 1)
                    begin
                        tmp = op.a;
                        op.a = op.b;
                        op.b = tmp;
                    end
                end
            end
            else
                op.func = amg_pkg::FUNC_REM_NODE;
            pending_ops.push_back(op);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("result %0d: %s is %0h, %0h was due", result_index, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_hold = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
                awaited_replies.push_back(apply_graph_op(op_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                next_valid = 1'b0;
                if (send_hold > 0)
                    send_hold--;
                else if (pending_ops.size() > 0)
                begin
                    op_on_bus = pending_ops.pop_front();
                    s_axis_tdata <= {op_on_bus.eval, op_on_bus.nval, op_on_bus.b, op_on_bus.a};
                    s_axis_tuser <= op_on_bus.func;
                    next_valid = 1'b1;
                    send_hold = calm ? 0 : $urandom_range(0, 6);
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        graph_reply_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_index++;
                if (awaited_replies.size() == 0)
                    report_mismatch("status of a result with nothing awaited",
                                    32'(m_axis_tuser), 32'd0);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                    if (m_axis_tdata[3:0] !== want.label)
                        report_mismatch("node_label", 32'(m_axis_tdata[3:0]),
                                        32'(want.label));
                    if (m_axis_tdata[35:4] !== want.vout)
                        report_mismatch("value_out", m_axis_tdata[35:4], want.vout);
                    if (m_axis_tdata[40:36] !== want.ncount)
                        report_mismatch("node_count", 32'(m_axis_tdata[40:36]),
                                        32'(want.ncount));
                    if (m_axis_tdata[49:41] !== want.ecount)
                        report_mismatch("edge_count", 32'(m_axis_tdata[49:41]),
                                        32'(want.ecount));
                end
                take_hold = calm ? 0 : $urandom_range(0, 6);
            end
            if (take_hold > 0)
            begin
                take_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned mode_seq [7];
        int unsigned weights [7];
        bit          calm_seq [7];
        mode_seq = '{0, 1, 1, 0, 0, 1, 0};
        weights = '{30, 40, 15, 50, 10, 25, 35};
        calm_seq = '{0, 0, 1, 0, 0, 1, 0};
        for (int i = 0; i < NODES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_value[i] = '0;
            for (int j = 0; j < NODES; j++)
                link_word[i][j] = '0;
        end
        node_total = 0;
        edge_total = 0;
        directed_mode = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        result_index = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0);
        queue_op(amg_pkg::FUNC_ADD_NODE, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_NODE, 4'd15, 4'd15, 32'h0, 32'hFFFF_FFFF);
        queue_op(amg_pkg::FUNC_ADD_NODE, 4'd3, 4'd9, 32'h1234_5678, 32'h1);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd0, 4'd1, 32'h0, 32'hFFFF_FFFF);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd1, 4'd0, 32'h0, 32'd5);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd0, 4'd2, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd0, 4'd15, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd2, 4'd2, 32'h0, 32'h8000_0000);
        queue_op(amg_pkg::FUNC_REM_EDGE, 4'd1, 4'd0, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_REM_EDGE, 4'd0, 4'd1, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd0, 4'd1, 32'h0, 32'd7);
        queue_op(amg_pkg::FUNC_REM_NODE, 4'd0, 4'd0, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_REM_NODE, 4'd0, 4'd15, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_REM_NODE, 4'd15, 4'd0, 32'h0, 32'h0);
        wait_idle();

        set_mode(1'b1);
        queue_op(amg_pkg::FUNC_ADD_NODE, 4'd0, 4'd0, 32'hA5A5_A5A5, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd0, 4'd1, 32'h0, 32'd3);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd1, 4'd0, 32'h0, 32'd4);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd1, 4'd1, 32'h0, 32'd9);
        queue_op(amg_pkg::FUNC_REM_NODE, 4'd1, 4'd0, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd0, 4'd2, 32'h0, 32'd11);
        wait_idle();

        set_mode(1'b0);
        queue_op(amg_pkg::FUNC_REM_EDGE, 4'd2, 4'd0, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_ADD_EDGE, 4'd15, 4'd0, 32'h0, 32'd1);
        queue_op(amg_pkg::FUNC_REM_EDGE, 4'd0, 4'd15, 32'h0, 32'h0);
        queue_op(amg_pkg::FUNC_REM_EDGE, 4'd7, 4'd2, 32'h0, 32'h0);
        wait_idle();

        for (int p = 0; p < 7; p++)
        begin
            set_mode(mode_seq[p][0]);
            calm = calm_seq[p];
            run_random_phase(250, weights[p]);
            wait_idle();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
